// ----- hw/rtl/schm_pkg.sv -----
`timescale 1ns / 1ps
package schm_pkg;

  typedef enum logic [2:0] {
    OP_HOST_WRITE = 3'd0,
    OP_HOST_READ  = 3'd1,
    OP_CPU_WRITE  = 3'd2,
    OP_CPU_READ   = 3'd3,
    OP_DSP_WRITE  = 3'd4,
    OP_DSP_READ   = 3'd5,
    OP_BIO_POLL   = 3'd6,
    OP_TIMER      = 3'd7
  } opcode_e;

  // Host port byte offsets.
  localparam logic [10:0] HOST_CMD_LO  = 11'd0;
  localparam logic [10:0] HOST_CMD_HI  = 11'd1;
  localparam logic [10:0] HOST_MBX_LO  = 11'd2;
  localparam logic [10:0] HOST_MBX_HI  = 11'd3;
  localparam logic [10:0] HOST_DMA     = 11'd4;
  localparam logic [10:0] HOST_IRQ     = 11'd6;

  // CPU I/O map; bit 0 is ignored where a pair of addresses is decoded.
  localparam logic [10:0] CPU_CMD_STAT = 11'h400;
  localparam logic [10:0] CPU_MAILBOX  = 11'h480;
  localparam logic [10:0] CPU_DSP_XFER = 11'h500;
  localparam logic [10:0] CPU_CONTROL  = 11'h600;
  localparam logic [10:0] CPU_DMA      = 11'h680;
  localparam logic [10:0] CPU_IRQ_ACK  = 11'h700;

  // DSP ports.
  localparam logic [10:0] DSP_PORT0    = 11'd0;
  localparam logic [10:0] DSP_PORT1    = 11'd1;

  localparam logic [5:0]  POT_MAX      = 6'd63;
  localparam logic [5:0]  POT_MIN      = 6'd0;

  // Control register bits.
  localparam int unsigned CTRL_INC     = 1;
  localparam int unsigned CTRL_UP      = 2;
  localparam int unsigned CTRL_CS      = 3;
  localparam int unsigned CTRL_DSP_RUN = 4;
  localparam int unsigned CTRL_TMR_EN  = 5;

  typedef struct packed {
    logic [15:0] read_data;
    logic        dma_request_set;
    logic        dma_request_clear;
    logic        cpu_irq_set;
    logic        cpu_irq_clear;
    logic        dsp_reset_active;
    logic        dsp_irq_active;
    logic [5:0]  volume_step;
    logic        bio_level;
    logic [11:0] dac_sample;
    logic        dac_write;
  } result_t;

endpackage

// ----- hw/rtl/speech_card_host_mailbox_core.sv -----
`timescale 1ns / 1ps
// Mailbox and control glue of a speech coprocessor card.
// Input channel (in_valid_i / in_ready_o) carries one bus access or event per
// transaction: host, CPU or DSP reads and writes, a BIO poll or a timer event.
// Every input transaction yields exactly one result transaction on the output
// channel (out_valid_o / out_ready_i) carrying read data, the side-effect pulses
// and the current levels of DSP reset, DSP interrupt, volume and BIO flag.
// The decode and the state update happen at the accepting edge and the
// result sits in the output register from the next cycle on.
// Throughput is one transaction per cycle while the receiver keeps taking results;
// the single output register is the only stage, so the block takes a new transaction
// in the same cycle in which the held result is taken.
// When the receiver stalls, the result stays in the output register and
// in_ready_o drops until it is taken.
// Reset clears all mailboxes and the control register, sets the potentiometer
// to 63 and the BIO flag to one, and empties the output register.
module speech_card_host_mailbox_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [10:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic        timer_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        dma_request_set_o,
  output logic        dma_request_clear_o,
  output logic        cpu_irq_set_o,
  output logic        cpu_irq_clear_o,
  output logic        dsp_reset_active_o,
  output logic        dsp_irq_active_o,
  output logic [5:0]  volume_step_o,
  output logic        bio_level_o,
  output logic [11:0] dac_sample_o,
  output logic        dac_write_o
);

  logic [15:0] cmd_q, cmd_d;
  logic [15:0] stat_q, stat_d;
  logic [15:0] mbx_q, mbx_d;
  logic [7:0]  dma_q, dma_d;
  logic [15:0] xfer_q, xfer_d;
  logic [5:0]  ctrl_q, ctrl_d;
  logic [5:0]  pot_q, pot_d;
  logic        bio_q, bio_d;
  logic        irq_q, irq_d;
  logic        out_valid_q;
  schm_pkg::result_t res_q, res_d;

  logic          in_fire;
  logic [7:0]    wr_byte;
  logic [10:0]   addr_pair;
  schm_pkg::opcode_e op;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_byte    = write_data_i[7:0];
  assign addr_pair  = {address_i[10:1], 1'b0};
  assign op         = schm_pkg::opcode_e'(opcode_i);

  always_comb begin
    cmd_d  = cmd_q;
    stat_d = stat_q;
    mbx_d  = mbx_q;
    dma_d  = dma_q;
    xfer_d = xfer_q;
    ctrl_d = ctrl_q;
    pot_d  = pot_q;
    bio_d  = bio_q;
    irq_d  = irq_q;
    res_d  = '0;

    unique case (op)
      schm_pkg::OP_HOST_WRITE: begin
        if (address_i == schm_pkg::HOST_CMD_LO) begin
          cmd_d[7:0] = wr_byte;
        end else if (address_i == schm_pkg::HOST_CMD_HI) begin
          cmd_d[15:8] = wr_byte;
        end else if (address_i == schm_pkg::HOST_MBX_LO) begin
          mbx_d[7:0] = wr_byte;
        end else if (address_i == schm_pkg::HOST_MBX_HI) begin
          mbx_d[15:8] = wr_byte;
        end else if (address_i == schm_pkg::HOST_DMA) begin
          dma_d = wr_byte;
          res_d.dma_request_set = 1'b1;
        end else if (address_i == schm_pkg::HOST_IRQ) begin
          res_d.cpu_irq_set = 1'b1;
        end
      end
      schm_pkg::OP_HOST_READ: begin
        if (address_i == schm_pkg::HOST_CMD_LO) begin
          res_d.read_data = {8'd0, stat_q[7:0]};
        end else if (address_i == schm_pkg::HOST_CMD_HI) begin
          res_d.read_data = {8'd0, stat_q[15:8]};
        end else if (address_i == schm_pkg::HOST_MBX_LO) begin
          res_d.read_data = {8'd0, mbx_q[7:0]};
        end else if (address_i == schm_pkg::HOST_MBX_HI) begin
          res_d.read_data = {8'd0, mbx_q[15:8]};
        end else if (address_i == schm_pkg::HOST_DMA) begin
          res_d.read_data = {8'd0, dma_q};
          res_d.dma_request_set = 1'b1;
        end
      end
      schm_pkg::OP_CPU_WRITE: begin
        if (addr_pair == schm_pkg::CPU_CMD_STAT) begin
          stat_d = write_data_i;
        end else if (addr_pair == schm_pkg::CPU_MAILBOX) begin
          mbx_d = write_data_i;
        end else if (addr_pair == schm_pkg::CPU_DSP_XFER) begin
          xfer_d = write_data_i;
          bio_d  = 1'b0;
        end else if (addr_pair == schm_pkg::CPU_CONTROL) begin
          ctrl_d = write_data_i[5:0];
          // The pot steps on a rising INC edge while its chip select is low.
          if (!write_data_i[schm_pkg::CTRL_CS] && !ctrl_q[schm_pkg::CTRL_INC] &&
              write_data_i[schm_pkg::CTRL_INC]) begin
            if (write_data_i[schm_pkg::CTRL_UP]) begin
              if (pot_q != schm_pkg::POT_MAX) pot_d = pot_q + 6'd1;
            end else begin
              if (pot_q != schm_pkg::POT_MIN) pot_d = pot_q - 6'd1;
            end
          end
        end else if (address_i == schm_pkg::CPU_DMA) begin
          dma_d = wr_byte;
        end else if (addr_pair == schm_pkg::CPU_IRQ_ACK) begin
          res_d.cpu_irq_clear = 1'b1;
        end
      end
      schm_pkg::OP_CPU_READ: begin
        if (addr_pair == schm_pkg::CPU_CMD_STAT) begin
          res_d.read_data = cmd_q;
        end else if (addr_pair == schm_pkg::CPU_MAILBOX) begin
          res_d.read_data = mbx_q;
        end else if (address_i == schm_pkg::CPU_DMA) begin
          res_d.read_data = {8'd0, dma_q};
        end
      end
      schm_pkg::OP_DSP_WRITE: begin
        if (address_i == schm_pkg::DSP_PORT1) begin
          res_d.dac_sample = write_data_i[15:4];
          res_d.dac_write  = 1'b1;
        end
      end
      schm_pkg::OP_DSP_READ: begin
        if (address_i == schm_pkg::DSP_PORT0 || address_i == schm_pkg::DSP_PORT1) begin
          res_d.read_data = xfer_q;
          bio_d = 1'b1;
        end
      end
      schm_pkg::OP_BIO_POLL: begin
        res_d.dma_request_clear = bio_q;
        res_d.read_data = {15'd0, bio_q};
      end
      schm_pkg::OP_TIMER: begin
        irq_d = ctrl_q[schm_pkg::CTRL_TMR_EN] && !timer_level_i;
      end
      default: begin
      end
    endcase

    res_d.dsp_reset_active = !ctrl_d[schm_pkg::CTRL_DSP_RUN];
    res_d.dsp_irq_active   = irq_d;
    res_d.volume_step      = pot_d;
    res_d.bio_level        = bio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      stat_q      <= '0;
      mbx_q       <= '0;
      dma_q       <= '0;
      xfer_q      <= '0;
      ctrl_q      <= '0;
      pot_q       <= schm_pkg::POT_MAX;
      bio_q       <= 1'b1;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cmd_q  <= cmd_d;
        stat_q <= stat_d;
        mbx_q  <= mbx_d;
        dma_q  <= dma_d;
        xfer_q <= xfer_d;
        ctrl_q <= ctrl_d;
        pot_q  <= pot_d;
        bio_q  <= bio_d;
        irq_q  <= irq_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = res_q.read_data;
  assign dma_request_set_o   = res_q.dma_request_set;
  assign dma_request_clear_o = res_q.dma_request_clear;
  assign cpu_irq_set_o       = res_q.cpu_irq_set;
  assign cpu_irq_clear_o     = res_q.cpu_irq_clear;
  assign dsp_reset_active_o  = res_q.dsp_reset_active;
  assign dsp_irq_active_o    = res_q.dsp_irq_active;
  assign volume_step_o       = res_q.volume_step;
  assign bio_level_o         = res_q.bio_level;
  assign dac_sample_o        = res_q.dac_sample;
  assign dac_write_o         = res_q.dac_write;

  // Every accepted transaction leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // Card state moves only when a transaction is accepted.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(pot_q) && $stable(ctrl_q) && $stable(bio_q)))
    else $error("card state changed without a transaction");

  // The potentiometer moves by at most one step per transaction.
  a_pot_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pot_q == $past(pot_q) || pot_q == $past(pot_q) + 6'd1 ||
                 pot_q == $past(pot_q) - 6'd1))
    else $error("potentiometer jumped by more than one step");

  // A result carries at most one interrupt pulse and a DAC sample only with its strobe.
  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!(cpu_irq_set_o && cpu_irq_clear_o) &&
                     (dac_write_o || dac_sample_o == 12'd0)))
    else $error("inconsistent result fields");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned ITEM_COUNT   = 1900;
  localparam int unsigned PHASE_LEN    = 160;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_PRINTS   = 40;
  // Unmapped on the CPU port, so a read from it returns zero.
  localparam logic [10:0] CPU_ZERO_RD  = 11'h580;

  typedef struct {
    schm_pkg::opcode_e op;
    logic [10:0]       addr;
    logic [15:0]       wdata;
    logic              tlevel;
    bit                drain;
  } access_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  schm_pkg::opcode_e opcode = schm_pkg::OP_HOST_WRITE;
  logic [10:0]       address = '0;
  logic [15:0]       write_data = '0;
  logic              timer_level = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  schm_pkg::result_t got;

  access_t           pending[$];
  schm_pkg::result_t expected_results[$];
  int unsigned       accepted = 0;
  int unsigned       errors = 0;
  int unsigned       cycles = 0;

  // Card state as the predictor sees it.
  logic [15:0] cmd_word = '0;
  logic [15:0] status_word = '0;
  logic [15:0] mbx_word = '0;
  logic [7:0]  dma_byte = '0;
  logic [15:0] xfer_word = '0;
  logic [5:0]  ctrl_bits = '0;
  logic [5:0]  pot_pos = schm_pkg::POT_MAX;
  logic        bio_flag = 1'b1;
  logic        dsp_irq = 1'b0;

  speech_card_host_mailbox_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (opcode),
    .address_i           (address),
    .write_data_i        (write_data),
    .timer_level_i       (timer_level),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .read_data_o         (got.read_data),
    .dma_request_set_o   (got.dma_request_set),
    .dma_request_clear_o (got.dma_request_clear),
    .cpu_irq_set_o       (got.cpu_irq_set),
    .cpu_irq_clear_o     (got.cpu_irq_clear),
    .dsp_reset_active_o  (got.dsp_reset_active),
    .dsp_irq_active_o    (got.dsp_irq_active),
    .volume_step_o       (got.volume_step),
    .bio_level_o         (got.bio_level),
    .dac_sample_o        (got.dac_sample),
    .dac_write_o         (got.dac_write)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic schm_pkg::result_t mailbox_access(schm_pkg::opcode_e op,
                                                       logic [10:0] a, logic [15:0] d,
                                                       logic tl);
    schm_pkg::result_t r;
    logic [10:0]       pair;
    logic [7:0]        b;
    r = '0;
    pair = {a[10:1], 1'b0};
    b = d[7:0];
    case (op)
      schm_pkg::OP_HOST_WRITE: begin
        if (a == schm_pkg::HOST_CMD_LO) cmd_word[7:0] = b;
        else if (a == schm_pkg::HOST_CMD_HI) cmd_word[15:8] = b;
        else if (a == schm_pkg::HOST_MBX_LO) mbx_word[7:0] = b;
        else if (a == schm_pkg::HOST_MBX_HI) mbx_word[15:8] = b;
        else if (a == schm_pkg::HOST_DMA) begin
          dma_byte = b;
          r.dma_request_set = 1'b1;
        end else if (a == schm_pkg::HOST_IRQ) r.cpu_irq_set = 1'b1;
      end
      schm_pkg::OP_HOST_READ: begin
        if (a == schm_pkg::HOST_CMD_LO) r.read_data = {8'h00, status_word[7:0]};
        else if (a == schm_pkg::HOST_CMD_HI) r.read_data = {8'h00, status_word[15:8]};
        else if (a == schm_pkg::HOST_MBX_LO) r.read_data = {8'h00, mbx_word[7:0]};
        else if (a == schm_pkg::HOST_MBX_HI) r.read_data = {8'h00, mbx_word[15:8]};
        else if (a == schm_pkg::HOST_DMA) begin
          r.read_data = {8'h00, dma_byte};
          r.dma_request_set = 1'b1;
        end
      end
      schm_pkg::OP_CPU_WRITE: begin
        if (pair == schm_pkg::CPU_CMD_STAT) status_word = d;
        else if (pair == schm_pkg::CPU_MAILBOX) mbx_word = d;
        else if (pair == schm_pkg::CPU_DSP_XFER) begin
          xfer_word = d;
          bio_flag = 1'b0;
        end else if (pair == schm_pkg::CPU_CONTROL) begin
          // The pot moves only on a rising INC while chip select is low.
          if (!d[schm_pkg::CTRL_CS] && !ctrl_bits[schm_pkg::CTRL_INC] &&
              d[schm_pkg::CTRL_INC]) begin
            if (d[schm_pkg::CTRL_UP]) begin
              if (pot_pos != schm_pkg::POT_MAX) pot_pos = pot_pos + 6'd1;
            end else if (pot_pos != schm_pkg::POT_MIN) pot_pos = pot_pos - 6'd1;
          end
          ctrl_bits = d[5:0];
        end else if (a == schm_pkg::CPU_DMA) dma_byte = b;
        else if (pair == schm_pkg::CPU_IRQ_ACK) r.cpu_irq_clear = 1'b1;
      end
      schm_pkg::OP_CPU_READ: begin
        if (pair == schm_pkg::CPU_CMD_STAT) r.read_data = cmd_word;
        else if (pair == schm_pkg::CPU_MAILBOX) r.read_data = mbx_word;
        else if (a == schm_pkg::CPU_DMA) r.read_data = {8'h00, dma_byte};
      end
      schm_pkg::OP_DSP_WRITE: begin
        if (a == schm_pkg::DSP_PORT1) begin
          r.dac_sample = d[15:4];
          r.dac_write = 1'b1;
        end
      end
      schm_pkg::OP_DSP_READ: begin
        if (a == schm_pkg::DSP_PORT0 || a == schm_pkg::DSP_PORT1) begin
          r.read_data = xfer_word;
          bio_flag = 1'b1;
        end
      end
      schm_pkg::OP_BIO_POLL: begin
        r.dma_request_clear = bio_flag;
        r.read_data = {15'd0, bio_flag};
      end
      default: dsp_irq = ctrl_bits[schm_pkg::CTRL_TMR_EN] && !tl;
    endcase
    r.dsp_reset_active = !ctrl_bits[schm_pkg::CTRL_DSP_RUN];
    r.dsp_irq_active = dsp_irq;
    r.volume_step = pot_pos;
    r.bio_level = bio_flag;
    return r;
  endfunction

  task automatic add(schm_pkg::opcode_e op, logic [10:0] a, logic [15:0] d, logic tl);
    access_t t;
    t.op = op;
    t.addr = a;
    t.wdata = d;
    t.tlevel = tl;
    t.drain = 1'b0;
    pending.push_back(t);
  endtask

  task automatic add_control(bit inc, bit up, bit cs);
    logic [15:0] v;
    v = 16'($urandom);
    v[schm_pkg::CTRL_INC] = inc;
    v[schm_pkg::CTRL_UP] = up;
    v[schm_pkg::CTRL_CS] = cs;
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CONTROL | 11'($urandom_range(0, 1)), v,
        1'($urandom));
  endtask

  // A run of INC pulses in one direction; chip select is seldom high.
  task automatic add_pot_run(int unsigned steps, bit up);
    bit cs;
    for (int unsigned i = 0; i < steps; i++) begin
      cs = ($urandom_range(0, 9) == 0);
      add_control(1'b0, up, cs);
      add_control(1'b1, up, cs);
    end
  endtask

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [15:0] actual, logic [15:0] want);
    if (actual !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, actual, want));
  endtask

  function automatic int unsigned idle_pct(bit receiver, int unsigned n);
    int unsigned phase;
    phase = (n / PHASE_LEN) % 4;
    if (phase == 3) return 21;
    if (phase == (receiver ? 2 : 1)) return 45;
    return 0;
  endfunction

  // Driver: predicts each transaction as it is accepted, then presents the next one.
  always @(posedge clk_i) begin
    access_t nxt;
    logic    next_valid;
    bit      take;
    if (rst_ni) begin
      take = in_valid && in_ready;
      next_valid = in_valid;
      if (take) begin
        expected_results.push_back(mailbox_access(opcode, address, write_data, timer_level));
        accepted++;
      end
      if (take || !in_valid) begin
        next_valid = 1'b0;
        if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0, accepted)) begin
          if (!pending[0].drain || expected_results.size() == 0) begin
            nxt = pending.pop_front();
            opcode <= nxt.op;
            address <= nxt.addr;
            write_data <= nxt.wdata;
            timer_level <= nxt.tlevel;
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    schm_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) report_mismatch("result with nothing expected");
        else begin
          want = expected_results.pop_front();
          check_field("read_data", got.read_data, want.read_data);
          check_field("dma_request_set", 16'(got.dma_request_set), 16'(want.dma_request_set));
          check_field("dma_request_clear", 16'(got.dma_request_clear),
                      16'(want.dma_request_clear));
          check_field("cpu_irq_set", 16'(got.cpu_irq_set), 16'(want.cpu_irq_set));
          check_field("cpu_irq_clear", 16'(got.cpu_irq_clear), 16'(want.cpu_irq_clear));
          check_field("dsp_reset_active", 16'(got.dsp_reset_active),
                      16'(want.dsp_reset_active));
          check_field("dsp_irq_active", 16'(got.dsp_irq_active), 16'(want.dsp_irq_active));
          check_field("volume_step", 16'(got.volume_step), 16'(want.volume_step));
          check_field("bio_level", 16'(got.bio_level), 16'(want.bio_level));
          check_field("dac_sample", 16'(got.dac_sample), 16'(want.dac_sample));
          check_field("dac_write", 16'(got.dac_write), 16'(want.dac_write));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1, accepted));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    access_t     t;
    int unsigned first;
    int unsigned kind;
    bit          dir;

    // Directed accesses: every operation, mapped and unmapped decodes, extremes.
    add(schm_pkg::OP_BIO_POLL, 11'h7FF, 16'hFFFF, 1'b1);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_CMD_LO, 16'hFFA5, 1'b0);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_CMD_HI, 16'h005A, 1'b1);
    add(schm_pkg::OP_CPU_READ, schm_pkg::CPU_CMD_STAT | 11'd1, 16'h0000, 1'b0);
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CMD_STAT, 16'hFFFF, 1'b0);
    add(schm_pkg::OP_HOST_READ, schm_pkg::HOST_CMD_HI, 16'h0000, 1'b0);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_MBX_LO, 16'h0011, 1'b0);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_MBX_HI, 16'hAB22, 1'b0);
    add(schm_pkg::OP_CPU_READ, schm_pkg::CPU_MAILBOX, 16'h0000, 1'b0);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_DMA, 16'h00FF, 1'b0);
    add(schm_pkg::OP_HOST_READ, schm_pkg::HOST_DMA, 16'h0000, 1'b0);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_IRQ, 16'h0000, 1'b0);
    add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_DMA + 11'd1, 16'hFFFF, 1'b0);
    add(schm_pkg::OP_HOST_READ, 11'h7FF, 16'h0000, 1'b0);
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_DSP_XFER | 11'd1, 16'hBEEF, 1'b0);
    add(schm_pkg::OP_BIO_POLL, 11'd0, 16'h0000, 1'b0);
    add(schm_pkg::OP_DSP_READ, schm_pkg::DSP_PORT1, 16'h0000, 1'b0);
    add(schm_pkg::OP_DSP_READ, schm_pkg::DSP_PORT1 + 11'd1, 16'h0000, 1'b0);
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_IRQ_ACK | 11'd1, 16'h0000, 1'b0);
    add(schm_pkg::OP_CPU_READ, CPU_ZERO_RD, 16'h0000, 1'b0);
    // Step up at the top bound, then enable the DSP and the timer and step down.
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CONTROL, 16'h0006, 1'b0);
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CONTROL, 16'h0030, 1'b0);
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CONTROL | 11'd1, 16'h0032, 1'b0);
    add(schm_pkg::OP_TIMER, 11'd0, 16'h0000, 1'b0);
    add(schm_pkg::OP_TIMER, 11'd0, 16'h0000, 1'b1);
    add(schm_pkg::OP_DSP_WRITE, schm_pkg::DSP_PORT1, 16'hFFFF, 1'b0);
    add(schm_pkg::OP_DSP_WRITE, schm_pkg::DSP_PORT0, 16'h1234, 1'b0);
    add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_DMA, 16'h1234, 1'b0);
    add(schm_pkg::OP_CPU_READ, schm_pkg::CPU_DMA | 11'd1, 16'h0000, 1'b0);

    // Sweep the pot into both bounds; the first sweep waits for the card to drain.
    first = pending.size();
    add_pot_run(70, 1'b0);
    t = pending[first];
    t.drain = 1'b1;
    pending[first] = t;
    add_pot_run(70, 1'b1);

    while (pending.size() < ITEM_COUNT) begin
      first = pending.size();
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        dir = 1'($urandom);
        add_pot_run($urandom_range(1, 40), dir);
      end else if (kind < 40) begin
        add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_CMD_LO, 16'($urandom), 1'($urandom));
        add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_CMD_HI, 16'($urandom), 1'($urandom));
        add(schm_pkg::OP_CPU_READ, schm_pkg::CPU_CMD_STAT | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CMD_STAT | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_HOST_READ, schm_pkg::HOST_CMD_LO, 16'($urandom), 1'b0);
        add(schm_pkg::OP_HOST_READ, schm_pkg::HOST_CMD_HI, 16'($urandom), 1'b0);
        add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_MAILBOX | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_HOST_READ, schm_pkg::HOST_MBX_LO + 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_MBX_LO + 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_CPU_READ, schm_pkg::CPU_MAILBOX | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
      end else if (kind < 55) begin
        add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_DSP_XFER | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_BIO_POLL, 11'($urandom), 16'($urandom), 1'($urandom));
        add(schm_pkg::OP_DSP_READ, 11'($urandom_range(0, 2)), 16'($urandom), 1'b0);
        add(schm_pkg::OP_BIO_POLL, 11'($urandom), 16'($urandom), 1'($urandom));
      end else if (kind < 68) begin
        add(schm_pkg::OP_DSP_WRITE, 11'($urandom_range(0, 2)), 16'($urandom), 1'b0);
        add(schm_pkg::OP_TIMER, 11'($urandom), 16'($urandom), 1'($urandom));
        add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_CONTROL, 16'($urandom), 1'b0);
        add(schm_pkg::OP_TIMER, 11'($urandom), 16'($urandom), 1'($urandom));
      end else if (kind < 80) begin
        add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_DMA, 16'($urandom), 1'b0);
        add(schm_pkg::OP_HOST_READ, schm_pkg::HOST_DMA, 16'($urandom), 1'b0);
        add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_DMA | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_CPU_READ, schm_pkg::CPU_DMA | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_HOST_WRITE, schm_pkg::HOST_IRQ + 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
        add(schm_pkg::OP_CPU_WRITE, schm_pkg::CPU_IRQ_ACK | 11'($urandom_range(0, 1)),
            16'($urandom), 1'b0);
      end else if (kind < 90) begin
        // Small addresses hit the host offsets and DSP ports, mapped or not.
        for (int unsigned i = 0; i < 4; i++)
          add(schm_pkg::opcode_e'($urandom_range(0, 7)), 11'($urandom_range(0, 9)),
              16'($urandom), 1'($urandom));
      end else begin
        for (int unsigned i = 0; i < 4; i++)
          add(schm_pkg::opcode_e'($urandom_range(0, 7)), 11'($urandom), 16'($urandom),
              1'($urandom));
      end
      if ($urandom_range(0, 29) == 0) begin
        t = pending[first];
        t.drain = 1'b1;
        pending[first] = t;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
